// ===== design/sde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 digest engine package
// Shared types, round constants, initial hash values and sigma functions.
// ----------------------------------------------------------------------------
package sde_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned NUM_VARS  = 8;
	localparam int unsigned WIN_DEPTH = 16;
	localparam int unsigned NUM_ROUNDS = 64;
	localparam int unsigned LEN_W     = 64;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [NUM_VARS-1:0][WORD_W-1:0] vars_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_UPDATE,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		PAD_NONE,
		PAD_MARK,
		PAD_ZERO,
		PAD_LEN_LO,
		PAD_DONE
	} pad_t;

	typedef struct packed {
		logic push;
		logic init;
		logic step;
	} core_ctl_t;

	localparam word_t PAD_MARK_WORD = 32'h8000_0000;

	localparam word_t ROUND_K [NUM_ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam vars_t INIT_HASH = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage
`default_nettype wire

// ===== design/sde_sched.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message schedule window
// Sixteen-word shift line; loads block words and expands the schedule.
// ----------------------------------------------------------------------------
module sde_sched (
	input  wire                     clk,
	input  wire sde_pkg::core_ctl_t ctl,
	input  wire sde_pkg::word_t     word_in,
	output sde_pkg::word_t          wt
);

	sde_pkg::word_t win_q [sde_pkg::WIN_DEPTH];
	sde_pkg::word_t next_w;

	assign wt = win_q[0];
	assign next_w = sde_pkg::small_sigma1(win_q[14]) + win_q[9]
		+ sde_pkg::small_sigma0(win_q[1]) + win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.push || ctl.step) begin
			for (int i = 0; i < sde_pkg::WIN_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[sde_pkg::WIN_DEPTH-1] <= ctl.push ? word_in : next_w;
		end
	end

endmodule
`default_nettype wire

// ===== design/sde_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working variables and the shared compression round, one round per cycle.
// ----------------------------------------------------------------------------
module sde_round (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire sde_pkg::core_ctl_t ctl,
	input  wire sde_pkg::vars_t     hash_in,
	input  wire sde_pkg::word_t     k,
	input  wire sde_pkg::word_t     w,
	output sde_pkg::vars_t          vars
);

	sde_pkg::vars_t vars_q;
	sde_pkg::word_t t1;
	sde_pkg::word_t t2;
	sde_pkg::word_t ch;
	sde_pkg::word_t maj;

	assign vars = vars_q;

	always_comb begin
		ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
		maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
		t1  = vars_q[7] + sde_pkg::big_sigma1(vars_q[4]) + ch + k + w;
		t2  = sde_pkg::big_sigma0(vars_q[0]) + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vars_q <= '0;
		end else if (ctl.init) begin
			vars_q <= hash_in;
		end else if (ctl.step) begin
			vars_q[7] <= vars_q[6];
			vars_q[6] <= vars_q[5];
			vars_q[5] <= vars_q[4];
			vars_q[4] <= vars_q[3] + t1;
			vars_q[3] <= vars_q[2];
			vars_q[2] <= vars_q[1];
			vars_q[1] <= vars_q[0];
			vars_q[0] <= t1 + t2;
		end
	end

endmodule
`default_nettype wire

// ===== design/sha256_digest_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 digest engine
// Streaming SHA-256 with built-in padding and a shared round unit.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one big-endian message word per beat, byte count in tuser,
//   tlast on the final word (count zero with tlast sends an empty tail).
//   Master stream: eight digest words, index in tuser, tlast on the eighth.
//   Words are taken only while idle. Every sixteenth word starts a block:
//   the 64 rounds, one per cycle in the shared round unit, then the hash
//   update; no new word is taken until the block is through.
//   The final word adds the padding words and one or two blocks.
//   s_tready is low from the final word until the last digest word leaves.
//   Digest words sit in the hash registers; a stalled master side holds them
//   and the engine waits. After the eighth word the hash, length and block
//   position go back to their initial values for the next message.
//   Reset loads the initial hash values and leaves the engine idle and ready.
// ----------------------------------------------------------------------------
module sha256_digest_engine_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [31:0] data_word
	input  wire  [2:0]  s_tuser,   // [2:0] valid_bytes
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast
);

	sde_pkg::state_t     state_q, state_d;
	sde_pkg::pad_t       pad_q, pad_d;
	sde_pkg::vars_t      hash_q;
	sde_pkg::vars_t      vars;
	logic [sde_pkg::LEN_W-1:0] len_q, len_d;
	logic [3:0]          pos_q;
	logic [5:0]          round_q;
	logic [2:0]          idx_q;
	sde_pkg::core_ctl_t  ctl;
	sde_pkg::word_t      push_word;
	sde_pkg::word_t      wt;
	sde_pkg::word_t      tail_word;
	logic [2:0]          nb;
	logic                in_acc;
	logic                out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign nb = (s_tuser > 3'd4) ? 3'd4 : s_tuser;

	always_comb begin
		unique case (nb[1:0])
			2'd0: tail_word = 32'h8000_0000;
			2'd1: tail_word = {s_tdata[31:24], 24'h80_0000};
			2'd2: tail_word = {s_tdata[31:16], 16'h8000};
			2'd3: tail_word = {s_tdata[31:8], 8'h80};
			default: tail_word = 32'h8000_0000;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		pad_d   = pad_q;
		len_d   = len_q;
		unique case (state_q)
			sde_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (!s_tlast) begin
						len_d = len_q + sde_pkg::LEN_W'(32);
						pad_d = sde_pkg::PAD_NONE;
					end else begin
						len_d = len_q + sde_pkg::LEN_W'({nb, 3'b000});
						pad_d = nb[2] ? sde_pkg::PAD_MARK : sde_pkg::PAD_ZERO;
					end
					if (pos_q == 4'd15) begin
						state_d = sde_pkg::ST_ROUND;
					end else if (s_tlast) begin
						state_d = sde_pkg::ST_PAD;
					end
				end
			end
			sde_pkg::ST_PAD: begin
				unique case (pad_q)
					sde_pkg::PAD_MARK: pad_d = sde_pkg::PAD_ZERO;
					sde_pkg::PAD_ZERO: begin
						if (pos_q == 4'd14) begin
							pad_d = sde_pkg::PAD_LEN_LO;
						end
					end
					sde_pkg::PAD_LEN_LO: pad_d = sde_pkg::PAD_DONE;
					default: pad_d = pad_q;
				endcase
				if (pos_q == 4'd15) begin
					state_d = sde_pkg::ST_ROUND;
				end
			end
			sde_pkg::ST_ROUND: begin
				if (round_q == 6'(sde_pkg::NUM_ROUNDS - 1)) begin
					state_d = sde_pkg::ST_UPDATE;
				end
			end
			sde_pkg::ST_UPDATE: begin
				priority if (pad_q == sde_pkg::PAD_NONE) begin
					state_d = sde_pkg::ST_IDLE;
				end else if (pad_q == sde_pkg::PAD_DONE) begin
					state_d = sde_pkg::ST_OUT;
				end else begin
					state_d = sde_pkg::ST_PAD;
				end
			end
			sde_pkg::ST_OUT: begin
				if (out_acc && idx_q == 3'd7) begin
					state_d = sde_pkg::ST_IDLE;
					pad_d   = sde_pkg::PAD_NONE;
					len_d   = '0;
				end
			end
			default: state_d = sde_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl       = '0;
		push_word = s_tdata;
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		unique case (state_q)
			sde_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				ctl.push = in_acc;
				ctl.init = in_acc && (pos_q == 4'd15);
				if (s_tlast && !nb[2]) begin
					push_word = tail_word;
				end
			end
			sde_pkg::ST_PAD: begin
				ctl.push = 1'b1;
				ctl.init = (pos_q == 4'd15);
				unique case (pad_q)
					sde_pkg::PAD_MARK: push_word = sde_pkg::PAD_MARK_WORD;
					sde_pkg::PAD_ZERO: begin
						push_word = (pos_q == 4'd14) ? len_q[63:32] : '0;
					end
					sde_pkg::PAD_LEN_LO: push_word = len_q[31:0];
					default: push_word = '0;
				endcase
			end
			sde_pkg::ST_ROUND: ctl.step = 1'b1;
			sde_pkg::ST_UPDATE: ctl = '0;
			sde_pkg::ST_OUT: m_tvalid = 1'b1;
			default: ctl = '0;
		endcase
	end

	assign m_tdata = hash_q[idx_q];
	assign m_tuser = idx_q;
	assign m_tlast = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sde_pkg::ST_IDLE;
			pad_q   <= sde_pkg::PAD_NONE;
			len_q   <= '0;
			pos_q   <= '0;
			round_q <= '0;
			idx_q   <= '0;
			hash_q  <= sde_pkg::INIT_HASH;
		end else begin
			state_q <= state_d;
			pad_q   <= pad_d;
			len_q   <= len_d;
			if (ctl.push) begin
				pos_q <= pos_q + 4'd1;
			end
			if (ctl.step) begin
				round_q <= round_q + 6'd1;
			end
			if (state_q == sde_pkg::ST_UPDATE) begin
				for (int j = 0; j < sde_pkg::NUM_VARS; j++) begin
					hash_q[j] <= hash_q[j] + vars[j];
				end
			end
			if (out_acc) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					hash_q <= sde_pkg::INIT_HASH;
				end
			end
		end
	end

	sde_sched u_sched (
		.clk     (clk),
		.ctl     (ctl),
		.word_in (push_word),
		.wt      (wt)
	);

	sde_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.hash_in (hash_q),
		.k       (sde_pkg::ROUND_K[round_q]),
		.w       (wt),
		.vars    (vars)
	);

endmodule
`default_nettype wire
